[rtl/sfc_pkg.sv]
package sfc_pkg;

   // SLIP special characters
   localparam logic [7:0] SLIP_END     = 8'hC0;
   localparam logic [7:0] SLIP_ESC     = 8'hDB;
   localparam logic [7:0] SLIP_ESC_END = 8'hDC;
   localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

   // most results one request can cause (END, ESC, ESC_x, END)
   localparam int MAX_RESULTS = 4;
   localparam int SLOT_IDX_W  = $clog2(MAX_RESULTS);

   // default depth of the plan queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // direction register codes
   typedef enum logic {
      DIR_ENCODE = 1'b0,
      DIR_DECODE = 1'b1
   } dir_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_END_OK  = 2'd1,
      KIND_END_ERR = 2'd2
   } kind_type;

   // one result
   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
   } slot_type;

   // all results of one request: count minus one, then the slots in order
   typedef struct packed {
      logic [SLOT_IDX_W-1:0]         last_idx;
      slot_type [MAX_RESULTS-1:0]    slot;
   } plan_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic     valid;
      plan_type plan;
   } head_type;

endpackage

[rtl/sfc_front.sv]
module sfc_front
   import sfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_of_message,
   input  logic       req_last_of_message,
   input  logic       queue_full,
   output logic       push,
   output plan_type   push_plan
);

   dir_type direction_ff, direction_in;
   logic    escape_pending_ff, escape_pending_in;
   logic    discarding_ff, discarding_in;
   logic    accept;
   logic    [2:0] count;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && (count != 3'd0);

   // classify the request and build its list of results
   always_comb begin
      logic [2:0] n;
      logic       esc_n;
      logic       disc_n;
      n      = 3'd0;
      esc_n  = escape_pending_ff;
      disc_n = discarding_ff;
      push_plan = '0;
      if (direction_ff == DIR_ENCODE) begin
         if (req_first_of_message) begin
            push_plan.slot[n[SLOT_IDX_W-1:0]] = '{data: SLIP_END, kind: KIND_DATA};
            n = n + 3'd1;
         end
         if (req_data_byte == SLIP_END || req_data_byte == SLIP_ESC) begin
            push_plan.slot[n[SLOT_IDX_W-1:0]] = '{data: SLIP_ESC, kind: KIND_DATA};
            n = n + 3'd1;
            push_plan.slot[n[SLOT_IDX_W-1:0]] =
               '{data: (req_data_byte == SLIP_END) ? SLIP_ESC_END : SLIP_ESC_ESC,
                 kind: KIND_DATA};
            n = n + 3'd1;
         end else begin
            push_plan.slot[n[SLOT_IDX_W-1:0]] = '{data: req_data_byte, kind: KIND_DATA};
            n = n + 3'd1;
         end
         if (req_last_of_message) begin
            push_plan.slot[n[SLOT_IDX_W-1:0]] = '{data: SLIP_END, kind: KIND_DATA};
            n = n + 3'd1;
         end
      end else begin
         if (!discarding_ff) begin
            if (escape_pending_ff) begin
               esc_n = 1'b0;
               if (req_data_byte == SLIP_ESC_END) begin
                  push_plan.slot[n[SLOT_IDX_W-1:0]] = '{data: SLIP_END, kind: KIND_DATA};
                  n = n + 3'd1;
               end else if (req_data_byte == SLIP_ESC_ESC) begin
                  push_plan.slot[n[SLOT_IDX_W-1:0]] = '{data: SLIP_ESC, kind: KIND_DATA};
                  n = n + 3'd1;
               end else begin
                  disc_n = 1'b1;
               end
            end else if (req_data_byte == SLIP_ESC) begin
               esc_n = 1'b1;
            end else if (req_data_byte != SLIP_END) begin
               push_plan.slot[n[SLOT_IDX_W-1:0]] = '{data: req_data_byte, kind: KIND_DATA};
               n = n + 3'd1;
            end
         end
         // end-of-message report
         if (req_last_of_message) begin
            push_plan.slot[n[SLOT_IDX_W-1:0]] =
               '{data: 8'h00, kind: (disc_n || esc_n) ? KIND_END_ERR : KIND_END_OK};
            n      = n + 3'd1;
            esc_n  = 1'b0;
            disc_n = 1'b0;
         end
      end
      count              = n;
      push_plan.last_idx = SLOT_IDX_W'(n - 3'd1);
      escape_pending_in  = esc_n;
      discarding_in      = disc_n;
   end

   assign direction_in = csr_write_enable ? dir_type'(csr_write_data) : direction_ff;

   // direction register and decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff      <= DIR_ENCODE;
         escape_pending_ff <= 1'b0;
         discarding_ff     <= 1'b0;
      end else begin
         direction_ff <= direction_in;
         if (accept && direction_ff == DIR_DECODE) begin
            escape_pending_ff <= escape_pending_in;
            discarding_ff     <= discarding_in;
         end
      end
   end

endmodule

[rtl/sfc_queue.sv]
module sfc_queue
   import sfc_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  plan_type push_plan,
   output logic     full,
   input  logic     pop,
   output head_type head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   plan_type            entry_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head.valid = (count_ff != '0);
   assign head.plan  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_plan;
      end
   end

endmodule

[rtl/sfc_back.sv]
module sfc_back
   import sfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  head_type   head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_last_of_run
);

   logic [SLOT_IDX_W-1:0] idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            byte_ff, byte_in;
   kind_type              kind_ff, kind_in;
   logic                  last_ff, last_in;
   logic                  load;
   logic                  at_last;
   slot_type              cur;

   // output register takes a new result when empty or being drained
   assign load    = !valid_ff || rsp_ready;
   assign at_last = (idx_ff == head.plan.last_idx);
   assign cur     = head.plan.slot[idx_ff];
   assign pop     = load && head.valid && at_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = head.valid;
         if (head.valid) begin
            byte_in = cur.data;
            kind_in = cur.kind;
            last_in = at_last;
            idx_in  = at_last ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_last_of_run = last_ff;

endmodule

[rtl/slip_frame_codec.sv]
// Channel    Ports                                  Moves
// request    req_valid/req_ready, req_*             one stream or message byte
// response   rsp_valid/rsp_ready, rsp_*             one result (byte or end report)
// csr        csr_write_enable, csr_write_data       direction, 0 encode / 1 decode
//
// A request turns into 0..4 results; the back end sends one result per cycle
// while rsp_ready allows it; a request with no results is not queued.
// Plain bytes flow at one request per cycle while the plan queue has room;
// escape pairs and END framing stall the front only once the plan queue
// (Depth entries) fills up. Results pass the queue, then the output register.
// Synchronous reset clears direction, decoder flags, queue and output valid.
module slip_frame_codec
   import sfc_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_of_message,
   input  logic       req_last_of_message,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_last_of_run
);

   logic     push;
   plan_type push_plan;
   logic     queue_full;
   logic     pop;
   head_type head;

   sfc_front u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_first_of_message (req_first_of_message),
      .req_last_of_message  (req_last_of_message),
      .queue_full           (queue_full),
      .push                 (push),
      .push_plan            (push_plan)
   );

   sfc_queue #(
      .Depth (Depth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_plan (push_plan),
      .full      (queue_full),
      .pop       (pop),
      .head      (head)
   );

   sfc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_kind        (rsp_kind),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

[verif/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sfc_pkg::*;

   // one result of the codec as it leaves the response port
   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       last;
   } codec_out_t;

   // one directed request; typed rows carry their results written out by hand
   typedef struct packed {
      dir_type         dir;
      logic [7:0]      data;
      logic            first;
      logic            last;
      logic            typed;
      logic [2:0]      fix_n;
      logic [0:3][7:0] fix_b;
      logic [0:3][1:0] fix_k;
   } directed_row_t;

   localparam logic [0:3][1:0] ALL_DATA = {4{KIND_DATA}};
   localparam logic [0:3][1:0] DATA_OK  = {KIND_DATA, KIND_END_OK, KIND_DATA, KIND_DATA};
   localparam logic [0:3][1:0] ONLY_OK  = {KIND_END_OK, KIND_DATA, KIND_DATA, KIND_DATA};
   localparam logic [0:3][1:0] ONLY_ERR = {KIND_END_ERR, KIND_DATA, KIND_DATA, KIND_DATA};

   localparam int N_DIRECTED = 25;

   directed_row_t directed_rows [N_DIRECTED] = '{
      // encode: framing and escapes
      '{DIR_ENCODE, 8'h00, 1'b1, 1'b1, 1'b1, 3'd3, {8'hC0, 8'h00, 8'hC0, 8'h00}, ALL_DATA},
      '{DIR_ENCODE, 8'hC0, 1'b1, 1'b1, 1'b1, 3'd4, {8'hC0, 8'hDB, 8'hDC, 8'hC0}, ALL_DATA},
      '{DIR_ENCODE, 8'hDB, 1'b1, 1'b0, 1'b1, 3'd3, {8'hC0, 8'hDB, 8'hDD, 8'h00}, ALL_DATA},
      '{DIR_ENCODE, 8'hFF, 1'b0, 1'b0, 1'b1, 3'd1, {8'hFF, 8'h00, 8'h00, 8'h00}, ALL_DATA},
      '{DIR_ENCODE, 8'hDC, 1'b0, 1'b1, 1'b1, 3'd2, {8'hDC, 8'hC0, 8'h00, 8'h00}, ALL_DATA},
      '{DIR_ENCODE, 8'hDD, 1'b0, 1'b0, 1'b1, 3'd1, {8'hDD, 8'h00, 8'h00, 8'h00}, ALL_DATA},
      '{DIR_ENCODE, 8'h55, 1'b1, 1'b0, 1'b1, 3'd2, {8'hC0, 8'h55, 8'h00, 8'h00}, ALL_DATA},
      '{DIR_ENCODE, 8'hAA, 1'b0, 1'b1, 1'b1, 3'd2, {8'hAA, 8'hC0, 8'h00, 8'h00}, ALL_DATA},
      // decode: END dropped, valid escape pairs, clean end
      '{DIR_DECODE, 8'hC0, 1'b0, 1'b0, 1'b1, 3'd0, {8'h00, 8'h00, 8'h00, 8'h00}, ALL_DATA},
      '{DIR_DECODE, 8'h00, 1'b0, 1'b0, 1'b1, 3'd1, {8'h00, 8'h00, 8'h00, 8'h00}, ALL_DATA},
      '{DIR_DECODE, 8'hDB, 1'b0, 1'b0, 1'b1, 3'd0, {8'h00, 8'h00, 8'h00, 8'h00}, ALL_DATA},
      '{DIR_DECODE, 8'hDC, 1'b0, 1'b0, 1'b1, 3'd1, {8'hC0, 8'h00, 8'h00, 8'h00}, ALL_DATA},
      '{DIR_DECODE, 8'hDB, 1'b0, 1'b0, 1'b1, 3'd0, {8'h00, 8'h00, 8'h00, 8'h00}, ALL_DATA},
      '{DIR_DECODE, 8'hDD, 1'b0, 1'b0, 1'b1, 3'd1, {8'hDB, 8'h00, 8'h00, 8'h00}, ALL_DATA},
      '{DIR_DECODE, 8'hFF, 1'b0, 1'b1, 1'b1, 3'd2, {8'hFF, 8'h00, 8'h00, 8'h00}, DATA_OK},
      // decode: invalid escape, then the rest is discarded up to an error end
      '{DIR_DECODE, 8'hDB, 1'b0, 1'b0, 1'b1, 3'd0, {8'h00, 8'h00, 8'h00, 8'h00}, ALL_DATA},
      '{DIR_DECODE, 8'h41, 1'b0, 1'b0, 1'b1, 3'd0, {8'h00, 8'h00, 8'h00, 8'h00}, ALL_DATA},
      '{DIR_DECODE, 8'h42, 1'b0, 1'b0, 1'b1, 3'd0, {8'h00, 8'h00, 8'h00, 8'h00}, ALL_DATA},
      '{DIR_DECODE, 8'h43, 1'b0, 1'b1, 1'b1, 3'd1, {8'h00, 8'h00, 8'h00, 8'h00}, ONLY_ERR},
      // decode: trailing ESC, then first flag that decode ignores
      '{DIR_DECODE, 8'hDB, 1'b0, 1'b1, 1'b1, 3'd1, {8'h00, 8'h00, 8'h00, 8'h00}, ONLY_ERR},
      '{DIR_DECODE, 8'h11, 1'b1, 1'b1, 1'b1, 3'd2, {8'h11, 8'h00, 8'h00, 8'h00}, DATA_OK},
      // direction flipped while an escape is pending in the decoder
      '{DIR_DECODE, 8'hDB, 1'b0, 1'b0, 1'b0, 3'd0, {8'h00, 8'h00, 8'h00, 8'h00}, ALL_DATA},
      '{DIR_ENCODE, 8'hC0, 1'b0, 1'b0, 1'b0, 3'd0, {8'h00, 8'h00, 8'h00, 8'h00}, ALL_DATA},
      '{DIR_DECODE, 8'hDC, 1'b0, 1'b1, 1'b0, 3'd0, {8'h00, 8'h00, 8'h00, 8'h00}, ALL_DATA},
      '{DIR_DECODE, 8'hC0, 1'b0, 1'b1, 1'b1, 3'd1, {8'h00, 8'h00, 8'h00, 8'h00}, ONLY_OK}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic       csr_write_data = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_first_of_message = 1'b0;
   logic       req_last_of_message = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_kind;
   logic       rsp_last_of_run;

   // predictor state
   dir_type    dir_mode = DIR_ENCODE;
   logic       esc_seen = 1'b0;
   logic       in_discard = 1'b0;
   codec_out_t step_out [4];
   int         step_n;

   codec_out_t    coded_out_q [$];
   directed_row_t cur_row = '0;
   logic          cur_typed = 1'b0;
   logic          no_gaps = 1'b0;
   int            rsp_hold_cycles = 0;
   int            busy_items = 0;
   int            mismatches = 0;

   slip_frame_codec dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_first_of_message (req_first_of_message),
      .req_last_of_message  (req_last_of_message),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_kind             (rsp_kind),
      .rsp_last_of_run      (rsp_last_of_run)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("slip_frame_codec: mismatch");
      $finish;
   end

   task automatic note_mismatch(input string what);
      if (mismatches < 200) $display("%0t: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic void emit(input logic [7:0] b, input kind_type k);
      step_out[step_n] = '{data: b, kind: k, last: 1'b0};
      step_n++;
   endfunction

   // SLIP stuff/unstuff of one request; fills step_out, returns the result count
   function automatic int slip_codec_step(input logic [7:0] b, input logic first,
                                          input logic last);
      step_n = 0;
      if (dir_mode == DIR_ENCODE) begin
         if (first) emit(SLIP_END, KIND_DATA);
         if (b == SLIP_END) begin
            emit(SLIP_ESC, KIND_DATA);
            emit(SLIP_ESC_END, KIND_DATA);
         end else if (b == SLIP_ESC) begin
            emit(SLIP_ESC, KIND_DATA);
            emit(SLIP_ESC_ESC, KIND_DATA);
         end else begin
            emit(b, KIND_DATA);
         end
         if (last) emit(SLIP_END, KIND_DATA);
      end else begin
         if (!in_discard) begin
            if (esc_seen) begin
               esc_seen = 1'b0;
               if (b == SLIP_ESC_END) emit(SLIP_END, KIND_DATA);
               else if (b == SLIP_ESC_ESC) emit(SLIP_ESC, KIND_DATA);
               else in_discard = 1'b1;
            end else if (b == SLIP_ESC) begin
               esc_seen = 1'b1;
            end else if (b != SLIP_END) begin
               emit(b, KIND_DATA);
            end
         end
         // end report: error on discard or dangling ESC
         if (last) begin
            if (in_discard || esc_seen) emit(8'h00, KIND_END_ERR);
            else emit(8'h00, KIND_END_OK);
            esc_seen = 1'b0;
            in_discard = 1'b0;
         end
      end
      if (step_n > 0) step_out[step_n-1].last = 1'b1;
      return step_n;
   endfunction

   // track csr writes and accepted requests, queue what the codec owes
   always @(posedge clock) begin : req_watch
      int n;
      codec_out_t typed_out;
      if (reset) begin
         dir_mode = DIR_ENCODE;
         esc_seen = 1'b0;
         in_discard = 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_write_data) dir_mode = DIR_DECODE;
            else dir_mode = DIR_ENCODE;
         end
         if (req_valid && req_ready) begin
            n = slip_codec_step(req_data_byte, req_first_of_message, req_last_of_message);
            busy_items++;
            if (cur_typed) begin
               for (int i = 0; i < cur_row.fix_n; i++) begin
                  typed_out.data = cur_row.fix_b[i];
                  typed_out.kind = kind_type'(cur_row.fix_k[i]);
                  typed_out.last = (i == cur_row.fix_n - 1);
                  coded_out_q.push_back(typed_out);
               end
            end else begin
               for (int i = 0; i < n; i++) coded_out_q.push_back(step_out[i]);
            end
         end
      end
   end

   // compare each accepted result against the oldest one owed
   always @(posedge clock) begin : rsp_watch
      codec_out_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (coded_out_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result byte %h kind %0d last %b",
                                    rsp_out_byte, rsp_kind, rsp_last_of_run));
         end else begin
            want = coded_out_q.pop_front();
            if (rsp_out_byte !== want.data)
               note_mismatch($sformatf("out_byte %h, wanted %h", rsp_out_byte, want.data));
            if (rsp_kind !== want.kind)
               note_mismatch($sformatf("kind %0d, wanted %0d", rsp_kind, want.kind));
            if (rsp_last_of_run !== want.last)
               note_mismatch($sformatf("last_of_run %b, wanted %b",
                                       rsp_last_of_run, want.last));
         end
      end
   end

   // response side: random stall per result, one long hold on request
   initial begin : rsp_side
      int stall;
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 16);
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // offer one request after a random gap, return at the edge that takes it
   task automatic send_req(input logic [7:0] b, input logic f, input logic l);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_first_of_message <= f;
      req_last_of_message <= l;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop offering, let every owed result drain, then allow for in-flight work
   task automatic settle_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (coded_out_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_direction(input dir_type d);
      csr_write_enable <= 1'b1;
      csr_write_data <= d;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // byte mix weighted toward the SLIP specials
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 15);
      if (r < 4) return SLIP_END;
      if (r < 6) return SLIP_ESC;
      if (r == 6) return SLIP_ESC_END;
      if (r == 7) return SLIP_ESC_ESC;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_encode_msg();
      int   len;
      logic noisy, f, l;
      len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 8);
      noisy = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < len; i++) begin
         f = noisy ? 1'($urandom_range(0, 1)) : (i == 0);
         l = noisy ? 1'($urandom_range(0, 1)) : (i == len - 1);
         send_req(pick_byte(), f, l);
      end
   endtask

   // framed stream for the decoder; mostly well formed, some corrupted
   task automatic send_decode_msg();
      logic [7:0] body [$];
      logic [7:0] stream_q [$];
      int         len, mode, pos;
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) body.push_back(pick_byte());
      if ($urandom_range(0, 1)) stream_q.push_back(SLIP_END);
      foreach (body[i]) begin
         if (body[i] == SLIP_END) begin
            stream_q.push_back(SLIP_ESC);
            stream_q.push_back(SLIP_ESC_END);
         end else if (body[i] == SLIP_ESC) begin
            stream_q.push_back(SLIP_ESC);
            stream_q.push_back(SLIP_ESC_ESC);
         end else begin
            stream_q.push_back(body[i]);
         end
      end
      if ($urandom_range(0, 4) != 0) stream_q.push_back(SLIP_END);
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         stream_q.push_back(SLIP_ESC);
      end else if (mode == 1) begin
         pos = $urandom_range(0, stream_q.size());
         stream_q.insert(pos, 8'($urandom_range(0, 255)));
         stream_q.insert(pos, SLIP_ESC);
      end else if (mode == 2) begin
         stream_q.delete();
         for (int i = 0; i < len; i++) stream_q.push_back(8'($urandom_range(0, 255)));
      end
      foreach (stream_q[i])
         send_req(stream_q[i], 1'($urandom_range(0, 1)), i == stream_q.size() - 1);
   endtask

   initial begin : stimulus
      dir_type tbl_dir;
      int      base;
      int      wait_n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_direction(DIR_ENCODE);
      tbl_dir = DIR_ENCODE;

      // directed requests
      foreach (directed_rows[r]) begin
         if (directed_rows[r].dir != tbl_dir) begin
            settle_idle();
            write_direction(directed_rows[r].dir);
            tbl_dir = directed_rows[r].dir;
         end
         cur_typed <= directed_rows[r].typed;
         cur_row <= directed_rows[r];
         send_req(directed_rows[r].data, directed_rows[r].first, directed_rows[r].last);
      end
      cur_typed <= 1'b0;

      // random phases alternating direction; phase 2 also backs up the response side
      for (int p = 0; p < 8; p++) begin
         settle_idle();
         if (p % 2) write_direction(DIR_DECODE);
         else write_direction(DIR_ENCODE);
         no_gaps = (p == 2 || p == 5);
         if (p == 2) rsp_hold_cycles = 300;
         base = busy_items;
         while (busy_items - base < 25) begin
            if (p % 2) send_decode_msg();
            else send_encode_msg();
         end
      end
      no_gaps = 1'b0;

      // drain and finish
      req_valid <= 1'b0;
      @(posedge clock);
      for (wait_n = 0; wait_n < 5000 && coded_out_q.size() != 0; wait_n++)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (coded_out_q.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", coded_out_q.size()));
      if (mismatches == 0) begin
         $display("slip_frame_codec: match");
      end else begin
         $display("slip_frame_codec: mismatch");
      end
      $finish;
   end

endmodule
